FILE: rtl/core/kpu_pkg.sv
// shared types, constants and tables of the permutation unrank block
`timescale 1ns / 1ps
`default_nettype none

package kpu_pkg;

   localparam int SIZE_W = 4;
   localparam int RANK_W = 19;
   localparam int ELEM_W = 4;
   localparam int POS_W  = 4;
   localparam int FACT_W = 32;
   localparam int UPC_W  = 3;

   // datapath operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_INIT  = 3'd1;
   localparam logic [2:0] OP_SUB   = 3'd2;
   localparam logic [2:0] OP_DIGIT = 3'd3;
   localparam logic [2:0] OP_ERR   = 3'd4;
   localparam logic [2:0] OP_LAST  = 3'd5;

   // jump conditions
   localparam logic [2:0] COND_REQ_FIRE   = 3'd0;
   localparam logic [2:0] COND_BAD        = 3'd1;
   localparam logic [2:0] COND_PLACES_ZERO = 3'd2;
   localparam logic [2:0] COND_REM_LT     = 3'd3;
   localparam logic [2:0] COND_OUT_FREE   = 3'd4;

   // program steps
   localparam logic [UPC_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [UPC_W-1:0] STEP_CHECK = 3'd1;
   localparam logic [UPC_W-1:0] STEP_TOP   = 3'd2;
   localparam logic [UPC_W-1:0] STEP_DIV   = 3'd3;
   localparam logic [UPC_W-1:0] STEP_DIGIT = 3'd4;
   localparam logic [UPC_W-1:0] STEP_ERR   = 3'd5;
   localparam logic [UPC_W-1:0] STEP_LAST  = 3'd6;

   typedef struct packed {
      logic             accept;
      logic [2:0]       op;
      logic [2:0]       cond;
      logic [UPC_W-1:0] jump_true;
      logic [UPC_W-1:0] jump_false;
   } ucode_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] op;
   } ctrl_type;

   typedef struct packed {
      logic bad;
      logic places_zero;
      logic rem_lt;
      logic out_free;
   } stat_type;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_type w;
      begin
         unique case (upc)
            STEP_WAIT:  w = '{1'b1, OP_NONE,  COND_REQ_FIRE,    STEP_CHECK, STEP_WAIT};
            STEP_CHECK: w = '{1'b0, OP_INIT,  COND_BAD,         STEP_ERR,   STEP_TOP};
            STEP_TOP:   w = '{1'b0, OP_NONE,  COND_PLACES_ZERO, STEP_LAST,  STEP_DIV};
            STEP_DIV:   w = '{1'b0, OP_SUB,   COND_REM_LT,      STEP_DIGIT, STEP_DIV};
            STEP_DIGIT: w = '{1'b0, OP_DIGIT, COND_OUT_FREE,    STEP_TOP,   STEP_DIGIT};
            STEP_ERR:   w = '{1'b0, OP_ERR,   COND_OUT_FREE,    STEP_WAIT,  STEP_ERR};
            STEP_LAST:  w = '{1'b0, OP_LAST,  COND_OUT_FREE,    STEP_WAIT,  STEP_LAST};
            default:    w = '{1'b0, OP_NONE,  COND_REQ_FIRE,    STEP_WAIT,  STEP_WAIT};
         endcase
         return w;
      end
   endfunction

   // factorial table, saturated beyond a set size of 12
   function automatic logic [FACT_W-1:0] fact_of(input logic [SIZE_W-1:0] m);
      logic [FACT_W-1:0] f;
      begin
         unique case (m)
            4'd0:    f = 32'd1;
            4'd1:    f = 32'd1;
            4'd2:    f = 32'd2;
            4'd3:    f = 32'd6;
            4'd4:    f = 32'd24;
            4'd5:    f = 32'd120;
            4'd6:    f = 32'd720;
            4'd7:    f = 32'd5040;
            4'd8:    f = 32'd40320;
            4'd9:    f = 32'd362880;
            4'd10:   f = 32'd3628800;
            4'd11:   f = 32'd39916800;
            4'd12:   f = 32'd479001600;
            default: f = 32'hFFFF_FFFF;
         endcase
         return f;
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kpu_req_if.sv
// request channel carrying set size and rank
`timescale 1ns / 1ps
`default_nettype none

interface kpu_req_if;
   logic                        valid;
   logic                        ready;
   logic [kpu_pkg::SIZE_W-1:0]  set_size;
   logic [kpu_pkg::RANK_W-1:0]  rank;

   modport source (output valid, output set_size, output rank, input ready);
   modport sink (input valid, input set_size, input rank, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kpu_rsp_if.sv
// response channel carrying one permutation element per item
`timescale 1ns / 1ps
`default_nettype none

interface kpu_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [kpu_pkg::ELEM_W-1:0] element;
   logic [kpu_pkg::POS_W-1:0]  position;
   logic                       last;
   logic                       error;

   modport source (output valid, output element, output position, output last,
                   output error, input ready);
   modport sink (input valid, input element, input position, input last,
                 input error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kpu_sequencer.sv
// microcode sequencer: step counter, control rom and jump logic
`timescale 1ns / 1ps
`default_nettype none

module kpu_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire kpu_pkg::stat_type stat,
   output kpu_pkg::ctrl_type      ctrl
);
   import kpu_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   ucode_type        word;
   logic             taken;

   always_comb begin
      word = ucode_rom(upc_ff);
      unique case (word.cond)
         COND_REQ_FIRE:    taken = req_valid;
         COND_BAD:         taken = stat.bad;
         COND_PLACES_ZERO: taken = stat.places_zero;
         COND_REM_LT:      taken = stat.rem_lt;
         COND_OUT_FREE:    taken = stat.out_free;
         default:          taken = 1'b0;
      endcase
      upc_in      = taken ? word.jump_true : word.jump_false;
      ctrl.accept = word.accept;
      ctrl.op     = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/kpu_datapath.sv
// datapath: rank remainder, value list, quotient search and output register
`timescale 1ns / 1ps
`default_nettype none

module kpu_datapath #(
   parameter int MAX_N = 9
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kpu_pkg::ctrl_type ctrl,
   output kpu_pkg::stat_type      stat,
   kpu_req_if.sink                req_chan,
   kpu_rsp_if.source              rsp_chan
);
   import kpu_pkg::*;

   localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

   logic [SIZE_W-1:0] n_ff, n_in;
   logic [RANK_W-1:0] k_ff, k_in;
   logic [RANK_W-1:0] rem_ff, rem_in;
   logic [FACT_W-1:0] fact_ff, fact_in;
   logic [SIZE_W-1:0] places_ff, places_in;
   logic [POS_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [ELEM_W-1:0] vals_ff [MAX_N];
   logic [ELEM_W-1:0] vals_in [MAX_N];

   logic              out_valid_ff, out_valid_in;
   logic [ELEM_W-1:0] out_elem_ff, out_elem_in;
   logic [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic              out_last_ff, out_last_in;
   logic              out_err_ff, out_err_in;

   logic out_free;
   logic rem_lt;
   logic bad;

   always_comb begin
      out_free = !out_valid_ff || rsp_chan.ready;
      rem_lt   = {{(FACT_W - RANK_W){1'b0}}, rem_ff} < fact_ff;
      bad      = (n_ff == '0) || (n_ff > SIZE_W'(MAX_N)) || (k_ff == '0)
               || ({{(FACT_W - RANK_W){1'b0}}, k_ff} > fact_of(n_ff));
      stat.bad         = bad;
      stat.places_zero = (places_ff == '0);
      stat.rem_lt      = rem_lt;
      stat.out_free    = out_free;
      req_chan.ready   = ctrl.accept;
   end

   always_comb begin
      n_in         = n_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      fact_in      = fact_ff;
      places_in    = places_ff;
      step_in      = step_ff;
      pick_in      = pick_ff;
      vals_in      = vals_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_elem_in  = out_elem_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      if (ctrl.accept && req_chan.valid) begin
         n_in = req_chan.set_size;
         k_in = req_chan.rank;
      end

      unique case (ctrl.op)
         OP_NONE: begin
         end
         OP_INIT: begin
            rem_in    = k_ff - RANK_W'(1);
            fact_in   = fact_of(n_ff - SIZE_W'(1));
            places_in = n_ff - SIZE_W'(1);
            step_in   = '0;
            pick_in   = '0;
            for (int i = 0; i < MAX_N; i++) begin
               vals_in[i] = ELEM_W'(i + 1);
            end
         end
         OP_SUB: begin
            if (!rem_lt) begin
               rem_in  = rem_ff - fact_ff[RANK_W-1:0];
               pick_in = pick_ff + IDX_W'(1);
            end
         end
         OP_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_elem_in  = vals_ff[pick_ff];
               out_pos_in   = step_ff;
               out_last_in  = 1'b0;
               out_err_in   = 1'b0;
               for (int i = 0; i < MAX_N - 1; i++) begin
                  if (IDX_W'(i) >= pick_ff) begin
                     vals_in[i] = vals_ff[i + 1];
                  end
               end
               places_in = places_ff - SIZE_W'(1);
               fact_in   = fact_of(places_ff - SIZE_W'(1));
               step_in   = step_ff + POS_W'(1);
               pick_in   = '0;
            end
         end
         OP_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_elem_in  = '0;
               out_pos_in   = '0;
               out_last_in  = 1'b1;
               out_err_in   = 1'b1;
            end
         end
         OP_LAST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_elem_in  = vals_ff[0];
               out_pos_in   = step_ff;
               out_last_in  = 1'b1;
               out_err_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         fact_ff      <= '0;
         places_ff    <= '0;
         step_ff      <= '0;
         pick_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         fact_ff      <= fact_in;
         places_ff    <= places_in;
         step_ff      <= step_in;
         pick_ff      <= pick_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      vals_ff     <= vals_in;
      out_elem_ff <= out_elem_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.element  = out_elem_ff;
   assign rsp_chan.position = out_pos_ff;
   assign rsp_chan.last     = out_last_ff;
   assign rsp_chan.error    = out_err_ff;

endmodule

`default_nettype wire

FILE: rtl/core/kth_permutation_unrank.sv
// Permutation unranking through the factorial number system.
// req_chan takes a set size n and a 1-based rank k. rsp_chan returns the
// k-th lexicographic permutation of 1..n, one element per item in position
// order, with last set on the final element. A rank of zero or above n!, or
// a set size of zero or above MAX_N, returns a single item with error and
// last set and element and position zero.
// One item is worked on at a time. Each of the n-1 leading digits is found by
// repeated subtraction of the place factorial in the shared subtractor. A
// microcode rom steps the datapath through check, quotient search, emit and
// list shift.
// The response sits in an output register; while the receiver stalls, the
// sequencer holds on its emit step and resumes when the register drains.
// Synchronous reset returns the sequencer to waiting and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module kth_permutation_unrank #(
   parameter int MAX_N = 9
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kpu_req_if.sink    req_chan,
   kpu_rsp_if.source  rsp_chan
);
   import kpu_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   kpu_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   kpu_datapath #(
      .MAX_N (MAX_N)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: dv/kpu_perm_checker.sv
// checker for the permutation unrank block: predicts each element and compares
`timescale 1ns / 1ps

module kpu_perm_checker #(
   parameter int MAX_N = 9
) (
   input  logic clock,
   input  logic reset,
   kpu_req_if   req,
   kpu_rsp_if   rsp,
   output int   fail_count,
   output int   outstanding,
   output int   requests_seen,
   output int   elements_seen,
   output int   rejects_seen
);
   import kpu_pkg::*;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
      logic              last;
      logic              error;
   } perm_elem_type;

   perm_elem_type elem_q[$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      requests_seen = 0;
      elements_seen = 0;
      rejects_seen  = 0;
   end

   function automatic longint unsigned factorial(input int m);
      longint unsigned f;
      f = 1;
      for (int i = 2; i <= m; i++) f = f * i;
      return f;
   endfunction

   // factorial number system: one digit per position, picked from the unused values
   function automatic void unrank_permutation(input logic [SIZE_W-1:0] n,
                                              input logic [RANK_W-1:0] k);
      logic [ELEM_W-1:0] pool [MAX_N];
      int                count;
      int                pick;
      longint unsigned   rem;
      longint unsigned   place_fact;
      perm_elem_type     e;
      if (n == 0 || n > MAX_N || k == 0 || k > factorial(n)) begin
         e.element  = '0;
         e.position = '0;
         e.last     = 1'b1;
         e.error    = 1'b1;
         elem_q = {elem_q, e};
         return;
      end
      for (int i = 0; i < n; i++) pool[i] = ELEM_W'(i + 1);
      count      = n;
      rem        = k - 1;
      place_fact = factorial(n - 1);
      for (int p = 0; p < n; p++) begin
         pick = int'(rem / place_fact);
         if (pick >= count) pick = count - 1;
         e.element  = pool[pick];
         e.position = POS_W'(p);
         e.last     = (p == n - 1);
         e.error    = 1'b0;
         elem_q = {elem_q, e};
         for (int i = pick; i + 1 < count; i++) pool[i] = pool[i + 1];
         count--;
         rem = rem % place_fact;
         if (n - 1 - p > 0) place_fact = place_fact / (n - 1 - p);
      end
   endfunction

   always @(posedge clock) begin
      perm_elem_type want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            unrank_permutation(req.set_size, req.rank);
            requests_seen++;
         end
         if (rsp.valid && rsp.ready) begin
            elements_seen++;
            if (rsp.error) rejects_seen++;
            if (elem_q.size() == 0) begin
               $error("element item with nothing expected: element %0d position %0d",
                      rsp.element, rsp.position);
               fail_count++;
            end else begin
               want = elem_q.pop_front();
               if (rsp.element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp.element);
                  fail_count++;
               end
               if (rsp.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp.position);
                  fail_count++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp.last);
                  fail_count++;
               end
               if (rsp.error !== want.error) begin
                  $error("error: expected %0d, got %0d", want.error, rsp.error);
                  fail_count++;
               end
            end
         end
         outstanding = elem_q.size();
      end
   end

endmodule

FILE: dv/tb.sv
// top of the permutation unrank testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
   import kpu_pkg::*;

   localparam int MAX_N       = 9;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_ITEMS  = 300;

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   cycles;
   int   fail_count;
   int   outstanding;
   int   requests_seen;
   int   elements_seen;
   int   rejects_seen;

   kpu_req_if req_chan ();
   kpu_rsp_if rsp_chan ();

   kth_permutation_unrank #(.MAX_N(MAX_N)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   kpu_perm_checker #(.MAX_N(MAX_N)) perm_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .requests_seen (requests_seen),
      .elements_seen (elements_seen),
      .rejects_seen  (rejects_seen)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d elements still expected", cycles, outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic int unsigned rank_limit(input int n);
      int unsigned f;
      f = 1;
      for (int i = 2; i <= n; i++) f = f * i;
      return f;
   endfunction

   task automatic send_request(input logic [SIZE_W-1:0] n, input logic [RANK_W-1:0] k);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.set_size <= n;
      req_chan.rank     <= k;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      int unsigned pick;
      int          n;
      reset             = 1'b1;
      idle_pct          = 0;
      stall_pct         = 0;
      req_chan.valid    = 1'b0;
      req_chan.set_size = '0;
      req_chan.rank     = '0;
      rsp_chan.ready    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: edges of the fields and every reject case
      send_request(4'd1, 19'd1);
      send_request(4'd1, 19'd0);
      send_request(4'd1, 19'd2);
      send_request(4'd0, 19'd1);
      send_request(4'd10, 19'd1);
      send_request(4'd15, 19'h7FFFF);
      send_request(4'd15, 19'd0);
      send_request(4'd2, 19'd1);
      send_request(4'd2, 19'd2);
      send_request(4'd2, 19'd3);
      send_request(4'd3, 19'd4);
      send_request(4'd3, 19'd6);
      send_request(4'd4, 19'd24);
      send_request(4'd5, 19'd120);
      send_request(4'd6, 19'd721);
      send_request(4'd7, 19'd5040);
      send_request(4'd8, 19'd40320);
      send_request(4'd8, 19'd40321);
      send_request(4'd9, 19'd1);
      send_request(4'd9, 19'd362880);
      send_request(4'd9, 19'd362881);
      send_request(4'd9, 19'h7FFFF);
      send_request(4'd9, 19'h2AAAA);
      send_request(4'd9, 19'h15555);

      // random, four phases of idling and back-pressure
      for (int i = 0; i < RAND_ITEMS; i++) begin
         case (i / (RAND_ITEMS / 4))
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 47; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 7;  stall_pct = 7;  end
         endcase
         pick = $urandom_range(99);
         if (pick < 80) begin
            n = $urandom_range(1, MAX_N);
            send_request(SIZE_W'(n), RANK_W'($urandom_range(1, rank_limit(n))));
         end else if (pick < 88) begin
            n = $urandom_range(1, MAX_N);
            send_request(SIZE_W'(n), $urandom_range(1) ? RANK_W'(0) : RANK_W'(rank_limit(n) + 1));
         end else if (pick < 94) begin
            n = $urandom_range(1) ? 0 : $urandom_range(MAX_N + 1, 15);
            send_request(SIZE_W'(n), RANK_W'($urandom));
         end else begin
            send_request(SIZE_W'($urandom), RANK_W'($urandom));
         end
      end
      req_chan.valid <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(posedge clock);

      $display("run covered %0d requests (%0d rejected) and %0d checked elements",
               requests_seen, rejects_seen, elements_seen);
      $display("with free flow, sender gaps, receiver stalls and light mixed idling");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: kth_permutation_unrank.f
rtl/core/kpu_pkg.sv
rtl/core/kpu_req_if.sv
rtl/core/kpu_rsp_if.sv
rtl/core/kpu_sequencer.sv
rtl/core/kpu_datapath.sv
rtl/core/kth_permutation_unrank.sv
dv/kpu_perm_checker.sv
dv/tb.sv
